@@ rtl/core/pmt_pkg.sv @@
// Shared types and constants for the PS/2 mouse tracker.
package pmt_pkg;

  // Bytes seen on the PS/2 link
  localparam logic [7:0] BYTE_ACK             = 8'hFA;
  localparam logic [7:0] BYTE_SELF_TEST_OK    = 8'hAA;
  localparam logic [7:0] BYTE_DEVICE_ID       = 8'h00;
  localparam logic [7:0] CMD_ENABLE_REPORTING = 8'hF4;

  // Sign bits of the deltas in the first packet byte
  localparam int X_SIGN_BIT = 4;
  localparam int Y_SIGN_BIT = 5;

  // Default geometry and fixed-point format
  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 240;
  localparam int DEF_FRACTION_BITS = 3;

  // Job queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // Link bring-up state
  typedef enum logic [1:0] {
    LINK_IDLE   = 2'd0,
    LINK_AWAIT  = 2'd1,
    LINK_REPORT = 2'd2
  } link_t;

  // Work handed from the front end to the back end
  typedef enum logic [1:0] {
    JOB_CMD    = 2'd0,
    JOB_ENABLE = 2'd1,
    JOB_PACKET = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } job_t;

  // Result kinds; the value also indexes the pending vector of the back end
  typedef enum logic [2:0] {
    EV_SEND_CMD = 3'd0,
    EV_ENABLED  = 3'd1,
    EV_MOVE     = 3'd2,
    EV_BTN_UP   = 3'd3,
    EV_BTN_DOWN = 3'd4
  } ev_kind_t;

  localparam int EV_COUNT = 5;

endpackage

@@ rtl/core/pmt_front.sv @@
// Front end: takes received bytes, tracks link bring-up and packet phase, queues jobs.
module pmt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    rx_byte,
  input  logic          queue_full,
  output logic          push,
  output pmt_pkg::job_t push_job
);
  import pmt_pkg::*;

  link_t      link, link_next;
  logic [1:0] phase, phase_next;
  logic [7:0] hist_mid;
  logic [7:0] hist_new;
  logic       job_valid;
  logic       accept;

  // Hold bytes back while the job queue has no room
  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && job_valid;

  // Classify the incoming byte against the history
  always_comb begin
    link_next     = link;
    phase_next    = phase;
    job_valid     = 1'b0;
    push_job.kind = JOB_CMD;
    push_job.b0   = hist_mid;
    push_job.b1   = hist_new;
    push_job.b2   = rx_byte;
    if (link != LINK_REPORT) begin
      if (hist_new == BYTE_SELF_TEST_OK && rx_byte == BYTE_DEVICE_ID) begin
        link_next     = LINK_AWAIT;
        job_valid     = 1'b1;
        push_job.kind = JOB_CMD;
      end else if (link == LINK_AWAIT && rx_byte == BYTE_ACK) begin
        link_next     = LINK_REPORT;
        job_valid     = 1'b1;
        push_job.kind = JOB_ENABLE;
      end
    end else begin
      // Every third byte closes a packet
      if (phase == 2'd2) begin
        phase_next    = 2'd0;
        job_valid     = 1'b1;
        push_job.kind = JOB_PACKET;
      end else begin
        phase_next = phase + 2'd1;
      end
    end
  end

  // Advance link state and phase on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      link  <= LINK_IDLE;
      phase <= 2'd0;
    end else if (accept) begin
      link  <= link_next;
      phase <= phase_next;
    end
  end

  // Shift the byte history
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_mid <= 8'h00;
      hist_new <= 8'h00;
    end else if (accept) begin
      hist_mid <= hist_new;
      hist_new <= rx_byte;
    end
  end

endmodule

@@ rtl/core/pmt_queue.sv @@
// Short job queue between the front and back ends.
module pmt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pmt_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output pmt_pkg::job_t head_job
);
  import pmt_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);

  job_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = entries[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/pmt_back.sv @@
// Back end: applies packets to position and buttons and emits result beats.
module pmt_back #(
  parameter int SCREEN_WIDTH  = pmt_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pmt_pkg::DEF_SCREEN_HEIGHT,
  parameter int FRACTION_BITS = pmt_pkg::DEF_FRACTION_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic          cfg_wdata,
  input  logic          queue_empty,
  input  pmt_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    event_kind,
  output logic [7:0]    command_byte,
  output logic [8:0]    old_x,
  output logic [7:0]    old_y,
  output logic [8:0]    new_x,
  output logic [7:0]    new_y,
  output logic          left_btn,
  output logic          middle_btn,
  output logic          right_btn,
  output logic          last
);
  import pmt_pkg::*;

  localparam int XIW = $clog2(SCREEN_WIDTH);
  localparam int YIW = $clog2(SCREEN_HEIGHT);
  localparam int PXW = XIW + FRACTION_BITS;
  localparam int PYW = YIW + FRACTION_BITS;
  localparam int SW  = ((PXW > PYW) ? PXW : PYW) + 8;
  localparam int SHL = (FRACTION_BITS >= 3) ? FRACTION_BITS - 3 : 0;
  localparam int SHR = (FRACTION_BITS >= 3) ? 0 : 3 - FRACTION_BITS;
  localparam logic signed [SW-1:0] LIM_X = SW'(SCREEN_WIDTH * (1 << FRACTION_BITS));
  localparam logic signed [SW-1:0] LIM_Y = SW'(SCREEN_HEIGHT * (1 << FRACTION_BITS));
  localparam logic [PXW-1:0] MAX_X = PXW'((SCREEN_WIDTH - 1) * (1 << FRACTION_BITS));
  localparam logic [PYW-1:0] MAX_Y = PYW'((SCREEN_HEIGHT - 1) * (1 << FRACTION_BITS));

  logic                 y_up;
  logic [PXW-1:0]       pos_x;
  logic [PYW-1:0]       pos_y;
  logic [2:0]           buttons;

  logic signed [SW-1:0] dx_ext, dy_ext, dx_s, dy_s;
  logic signed [SW-1:0] sum_x, sum_y;
  logic [PXW-1:0]       nx;
  logic [PYW-1:0]       ny;
  logic [2:0]           nb, up_new, down_new;
  logic                 moved;

  logic [EV_COUNT-1:0]  pend, pend_next, pend_load, pend_left, sel;
  logic [8:0]           mv_old_x, mv_new_x;
  logic [7:0]           mv_old_y, mv_new_y;
  logic [2:0]           up_mask, down_mask;
  logic                 emit;
  logic                 load_job;
  ev_kind_t             sel_kind;

  // Hold the vertical direction register
  always_ff @(posedge clk) begin
    if (rst) begin
      y_up <= 1'b0;
    end else if (cfg_write) begin
      y_up <= cfg_wdata;
    end
  end

  // Scale the 9-bit deltas into the fixed-point format
  always_comb begin
    dx_ext = SW'($signed({head_job.b0[X_SIGN_BIT], head_job.b1}));
    dy_ext = SW'($signed({head_job.b0[Y_SIGN_BIT], head_job.b2}));
    dx_s   = (dx_ext <<< SHL) >>> SHR;
    dy_s   = (dy_ext <<< SHL) >>> SHR;
    sum_x  = SW'($signed({1'b0, pos_x})) + dx_s;
    sum_y  = y_up ? SW'($signed({1'b0, pos_y})) + dy_s
                  : SW'($signed({1'b0, pos_y})) - dy_s;
  end

  // Clamp to the screen
  always_comb begin
    if (sum_x < 0) begin
      nx = '0;
    end else if (sum_x >= LIM_X) begin
      nx = MAX_X;
    end else begin
      nx = sum_x[PXW-1:0];
    end
    if (sum_y < 0) begin
      ny = '0;
    end else if (sum_y >= LIM_Y) begin
      ny = MAX_Y;
    end else begin
      ny = sum_y[PYW-1:0];
    end
  end

  // Work out which results a packet raises
  always_comb begin
    nb       = head_job.b0[2:0];
    up_new   = (buttons ^ nb) & ~nb;
    down_new = (buttons ^ nb) & nb;
    moved    = ((nx != pos_x) || (ny != pos_y)) &&
               ((|nx[PXW-1:FRACTION_BITS]) || (|ny[PYW-1:FRACTION_BITS]));
    pend_load = '0;
    case (head_job.kind)
      JOB_CMD:    pend_load[EV_SEND_CMD] = 1'b1;
      JOB_ENABLE: pend_load[EV_ENABLED]  = 1'b1;
      JOB_PACKET: begin
        pend_load[EV_MOVE]     = moved;
        pend_load[EV_BTN_UP]   = |up_new;
        pend_load[EV_BTN_DOWN] = |down_new;
      end
      default:    pend_load = '0;
    endcase
  end

  // Pick the next pending result and decide whether to take a new job
  always_comb begin
    sel       = pend & (~pend + EV_COUNT'(1));
    emit      = (|pend) && (!out_valid || !out_stall);
    pend_left = emit ? (pend & ~sel) : pend;
    load_job  = !queue_empty && (pend_left == '0);
    pend_next = load_job ? pend_load : pend_left;
    if (sel[EV_SEND_CMD]) begin
      sel_kind = EV_SEND_CMD;
    end else if (sel[EV_ENABLED]) begin
      sel_kind = EV_ENABLED;
    end else if (sel[EV_MOVE]) begin
      sel_kind = EV_MOVE;
    end else if (sel[EV_BTN_UP]) begin
      sel_kind = EV_BTN_UP;
    end else begin
      sel_kind = EV_BTN_DOWN;
    end
  end

  assign pop = load_job;

  // Track pending results
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  // Apply a packet to position and buttons
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      buttons <= 3'b000;
    end else if (load_job && head_job.kind == JOB_PACKET) begin
      pos_x   <= nx;
      pos_y   <= ny;
      buttons <= nb;
    end
  end

  // Capture the data of the pending results
  always_ff @(posedge clk) begin
    if (load_job && head_job.kind == JOB_PACKET) begin
      mv_old_x  <= 9'(pos_x[PXW-1:FRACTION_BITS]);
      mv_old_y  <= 8'(pos_y[PYW-1:FRACTION_BITS]);
      mv_new_x  <= 9'(nx[PXW-1:FRACTION_BITS]);
      mv_new_y  <= 8'(ny[PYW-1:FRACTION_BITS]);
      up_mask   <= up_new;
      down_mask <= down_new;
    end
  end

  // Output register valid: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      event_kind   <= sel_kind;
      command_byte <= (sel_kind == EV_SEND_CMD) ? CMD_ENABLE_REPORTING : 8'h00;
      old_x        <= (sel_kind == EV_MOVE) ? mv_old_x : 9'd0;
      old_y        <= (sel_kind == EV_MOVE) ? mv_old_y : 8'd0;
      new_x        <= (sel_kind == EV_MOVE) ? mv_new_x : 9'd0;
      new_y        <= (sel_kind == EV_MOVE) ? mv_new_y : 8'd0;
      if (sel_kind == EV_BTN_UP) begin
        left_btn   <= up_mask[0];
        right_btn  <= up_mask[1];
        middle_btn <= up_mask[2];
      end else if (sel_kind == EV_BTN_DOWN) begin
        left_btn   <= down_mask[0];
        right_btn  <= down_mask[1];
        middle_btn <= down_mask[2];
      end else begin
        left_btn   <= 1'b0;
        right_btn  <= 1'b0;
        middle_btn <= 1'b0;
      end
      last         <= ((pend & ~sel) == '0);
    end
  end

endmodule

@@ rtl/core/ps2_mouse_tracker_unit.sv @@
// PS/2 mouse tracker: byte-stream decoder with position and button event output.
// Received mouse bytes are accepted one per cycle while the four-entry job queue
// has room. The front end handles link bring-up (answering a self-test/ID pair
// with an enable-reporting command, then waiting for the acknowledge) and cuts
// the report stream into three-byte packets. The back end applies each packet
// to the clamped fixed-point cursor position and then delivers its results,
// one beat per cycle while the output is not stalled: a three-byte packet gives
// zero to three results, so the block keeps pace with a continuous byte stream.
// A stalled result waits in the output register and later results in the back
// end's pending vector; the queue absorbs bytes meanwhile. No clearing pass is
// needed after reset. y direction is set by the one-bit config write.
module ps2_mouse_tracker_unit #(
  parameter int SCREEN_WIDTH  = pmt_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pmt_pkg::DEF_SCREEN_HEIGHT,
  parameter int FRACTION_BITS = pmt_pkg::DEF_FRACTION_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] event_kind,
  output logic [7:0] command_byte,
  output logic [8:0] old_x,
  output logic [7:0] old_y,
  output logic [8:0] new_x,
  output logic [7:0] new_y,
  output logic       left_btn,
  output logic       middle_btn,
  output logic       right_btn,
  output logic       last
);
  import pmt_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;

  pmt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_job   (push_job)
  );

  pmt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head_job (head_job)
  );

  pmt_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_wdata    (cfg_wdata),
    .queue_empty  (queue_empty),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .command_byte (command_byte),
    .old_x        (old_x),
    .old_y        (old_y),
    .new_x        (new_x),
    .new_y        (new_y),
    .left_btn     (left_btn),
    .middle_btn   (middle_btn),
    .right_btn    (right_btn),
    .last         (last)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the PS/2 mouse tracker unit.
`timescale 1ns / 100ps

module tb;
  import pmt_pkg::*;

  localparam int SCR_W        = DEF_SCREEN_WIDTH;
  localparam int SCR_H        = DEF_SCREEN_HEIGHT;
  localparam int FRAC         = DEF_FRACTION_BITS;
  localparam int DIR_ROWS     = 24;
  localparam int PHASE_BYTES  = 114;
  localparam int SETTLE       = 16;
  localparam int DRAIN        = 40;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 20;

  // One result beat, field for field as it leaves the block
  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] cmd;
    logic [8:0] ox;
    logic [7:0] oy;
    logic [8:0] nx;
    logic [7:0] ny;
    logic       left;
    logic       middle;
    logic       right;
    logic       last;
  } mouse_ev_t;

  // How a directed row is checked: by the tracker model, by a fixed result, or as giving no result
  typedef enum logic [1:0] {
    CHK_PRED    = 2'd0,
    CHK_NONE    = 2'd1,
    CHK_CMD     = 2'd2,
    CHK_ENABLED = 2'd3
  } dir_chk_t;

  typedef struct packed {
    dir_chk_t   chk;
    logic [7:0] b;
  } dir_row_t;

  // Link bring-up, then packets: full-scale moves, a clamp at zero, a move into
  // the origin pixel, link bytes inside a packet, a button-only packet.
  dir_row_t dir_table [DIR_ROWS] = '{
    '{CHK_NONE, 8'hFA},     // ack with no command pending
    '{CHK_NONE, 8'hAA},
    '{CHK_NONE, 8'h01},     // self test followed by a wrong id
    '{CHK_NONE, 8'hAA},
    '{CHK_CMD, 8'h00},
    '{CHK_NONE, 8'hAA},
    '{CHK_CMD, 8'h00},      // self test again while awaiting the ack
    '{CHK_NONE, 8'h55},
    '{CHK_ENABLED, 8'hFA},
    '{CHK_PRED, 8'h0F}, '{CHK_PRED, 8'hFF}, '{CHK_PRED, 8'h00},
    '{CHK_PRED, 8'h38}, '{CHK_PRED, 8'h00}, '{CHK_PRED, 8'h00},
    '{CHK_PRED, 8'h08}, '{CHK_PRED, 8'h00}, '{CHK_PRED, 8'hFF},
    '{CHK_PRED, 8'hAA}, '{CHK_PRED, 8'hFA}, '{CHK_PRED, 8'hAA},
    '{CHK_PRED, 8'h08}, '{CHK_PRED, 8'h00}, '{CHK_PRED, 8'h00}
  };

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] event_kind;
  logic [7:0] command_byte;
  logic [8:0] old_x;
  logic [7:0] old_y;
  logic [8:0] new_x;
  logic [7:0] new_y;
  logic       left_btn;
  logic       middle_btn;
  logic       right_btn;
  logic       last;

  // Tracker state kept alongside the block
  bit         y_up;
  link_t      link;
  logic [7:0] hist [3];
  logic [1:0] phase;
  int         cur_x;
  int         cur_y;
  logic [2:0] btn_state;

  mouse_ev_t  step_events[$];
  mouse_ev_t  pending_events[$];

  bit bursty   = 1'b1;
  bit hold_req = 1'b0;
  int errors;
  int n_bytes;
  int n_beats;
  int n_in_held;
  int n_clamp_lo;
  int n_clamp_hi;
  int cycle_count;

  ps2_mouse_tracker_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .command_byte (command_byte),
    .old_x        (old_x),
    .old_y        (old_y),
    .new_x        (new_x),
    .new_y        (new_y),
    .left_btn     (left_btn),
    .middle_btn   (middle_btn),
    .right_btn    (right_btn),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Scale a raw delta into fixed-point steps, rounding toward minus infinity
  function automatic int scale_delta(input int d);
    int v;
    v = d * (1 << FRAC);
    if (v >= 0) return v / 8;
    return -((-v + 7) / 8);
  endfunction

  // Clamp one axis to the screen; the far edge lands on a whole pixel
  function automatic int clamp_axis(input int p, input int size);
    if (p < 0) begin
      n_clamp_lo++;
      return 0;
    end
    if (p >= (size << FRAC)) begin
      n_clamp_hi++;
      return (size - 1) << FRAC;
    end
    return p;
  endfunction

  function automatic void add_event(input ev_kind_t k, input logic [7:0] cmd,
                                    input int ox, input int oy, input int nx,
                                    input int ny, input logic [2:0] btn);
    mouse_ev_t e;
    e        = '0;
    e.kind   = k;
    e.cmd    = cmd;
    e.ox     = 9'(ox);
    e.oy     = 8'(oy);
    e.nx     = 9'(nx);
    e.ny     = 8'(ny);
    e.left   = btn[0];
    e.middle = btn[2];
    e.right  = btn[1];
    step_events.push_back(e);
  endfunction

  // Advance the tracker by one received byte and collect the events it causes
  function automatic void track_byte(input logic [7:0] b);
    int         dx;
    int         dy;
    int         ox;
    int         oy;
    logic [2:0] nb;
    logic [2:0] changed;
    step_events.delete();
    hist[0] = hist[1];
    hist[1] = hist[2];
    hist[2] = b;
    if (link != LINK_REPORT) begin
      if (hist[1] == BYTE_SELF_TEST_OK && hist[2] == BYTE_DEVICE_ID) begin
        link = LINK_AWAIT;
        add_event(EV_SEND_CMD, CMD_ENABLE_REPORTING, 0, 0, 0, 0, 3'b000);
      end else if (link == LINK_AWAIT && hist[2] == BYTE_ACK) begin
        link = LINK_REPORT;
        add_event(EV_ENABLED, 8'h00, 0, 0, 0, 0, 3'b000);
      end
    end else begin
      phase = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
      if (phase == 2'd0) begin
        dx = int'(hist[1]) - (hist[0][X_SIGN_BIT] ? 256 : 0);
        dy = int'(hist[2]) - (hist[0][Y_SIGN_BIT] ? 256 : 0);
        ox = cur_x;
        oy = cur_y;
        nb = hist[0][2:0];
        cur_x = clamp_axis(cur_x + scale_delta(dx), SCR_W);
        if (y_up) cur_y = clamp_axis(cur_y + scale_delta(dy), SCR_H);
        else cur_y = clamp_axis(cur_y - scale_delta(dy), SCR_H);
        if ((ox != cur_x || oy != cur_y) &&
            ((cur_x >> FRAC) != 0 || (cur_y >> FRAC) != 0))
          add_event(EV_MOVE, 8'h00, ox >> FRAC, oy >> FRAC,
                    cur_x >> FRAC, cur_y >> FRAC, 3'b000);
        changed   = btn_state ^ nb;
        btn_state = nb;
        if ((changed & ~nb) != 3'b000)
          add_event(EV_BTN_UP, 8'h00, 0, 0, 0, 0, changed & ~nb);
        if ((changed & nb) != 3'b000)
          add_event(EV_BTN_DOWN, 8'h00, 0, 0, 0, 0, changed & nb);
      end
    end
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
  endfunction

  function automatic string ev_str(input mouse_ev_t e);
    return $sformatf("kind=%0d cmd=%02h old=(%0d,%0d) new=(%0d,%0d) lmr=%b%b%b last=%b",
                     e.kind, e.cmd, e.ox, e.oy, e.nx, e.ny,
                     e.left, e.middle, e.right, e.last);
  endfunction

  // Offer one byte, hold it until accepted, then queue what it should cause
  task automatic send_byte(input logic [7:0] b, input dir_chk_t chk);
    mouse_ev_t e;
    @(negedge clk);
    if (bursty && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    n_bytes++;
    track_byte(b);
    e      = '0;
    e.last = 1'b1;
    case (chk)
      CHK_PRED: foreach (step_events[i]) pending_events.push_back(step_events[i]);
      CHK_CMD: begin
        e.kind = EV_SEND_CMD;
        e.cmd  = CMD_ENABLE_REPORTING;
        pending_events.push_back(e);
      end
      CHK_ENABLED: begin
        e.kind = EV_ENABLED;
        pending_events.push_back(e);
      end
      default: ;
    endcase
  endtask

  // Let the block drain, then write the y direction register
  task automatic set_y_dir(input bit v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    y_up = v;
  endtask

  // Result side: random stall bursts, free stretches, and one long hold-off
  initial begin
    int  run_left;
    bit  run_stall;
    run_left  = 0;
    run_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        if (hold_req) begin
          hold_req  = 1'b0;
          run_stall = 1'b1;
          run_left  = HOLD_CYCLES;
        end else begin
          run_stall = bursty && ($urandom_range(0, 2) == 0);
          run_left  = $urandom_range(1, 14);
        end
      end
      run_left--;
      out_stall <= run_stall;
    end
  end

  // Check each accepted result beat against the oldest expectation
  always @(posedge clk) begin
    mouse_ev_t got;
    mouse_ev_t want;
    if (!rst && out_valid && !out_stall) begin
      got.kind   = ev_kind_t'(event_kind);
      got.cmd    = command_byte;
      got.ox     = old_x;
      got.oy     = old_y;
      got.nx     = new_x;
      got.ny     = new_y;
      got.left   = left_btn;
      got.middle = middle_btn;
      got.right  = right_btn;
      got.last   = last;
      n_beats++;
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected beat, expected none, actual %s",
                   $time, ev_str(got));
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: beat mismatch", $time);
            $display("  expected %s", ev_str(want));
            $display("  actual   %s", ev_str(got));
          end
        end
      end
    end
  end

  // Watchdog and back-pressure count
  always @(posedge clk) begin
    cycle_count++;
    if (in_valid && in_stall) n_in_held++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding",
               $time, pending_events.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then random packets over four phases
  initial begin
    int         start;
    int         pkt;
    int         dir_x;
    int         dir_y;
    logic [7:0] b0;
    logic [7:0] bx;
    logic [7:0] by;
    y_up      = 1'b0;
    link      = LINK_IDLE;
    hist[0]   = 8'h00;
    hist[1]   = 8'h00;
    hist[2]   = 8'h00;
    phase     = 2'd0;
    cur_x     = 0;
    cur_y     = 0;
    btn_state = 3'b000;
    dir_x     = 2;
    dir_y     = 2;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    set_y_dir(1'b0);
    for (int i = 0; i < DIR_ROWS; i++) send_byte(dir_table[i].b, dir_table[i].chk);

    for (int ph = 0; ph < 4; ph++) begin
      set_y_dir(ph % 2 == 0);
      if (ph == 0) hold_req = 1'b1;
      if (ph == 3) bursty = 1'b0;
      start = n_bytes;
      pkt   = 0;
      while (n_bytes - start < PHASE_BYTES) begin
        // pick a drift per axis: 0 toward zero, 1 toward the far edge, 2 free
        if (pkt % 8 == 0) begin
          dir_x = $urandom_range(0, 2);
          dir_y = $urandom_range(0, 2);
        end
        pkt++;
        if ($urandom_range(0, 19) == 0) begin
          // stray byte: shifts the packet framing
          send_byte(8'($urandom_range(0, 255)), CHK_PRED);
        end else begin
          b0 = 8'($urandom_range(0, 255));
          bx = 8'($urandom_range(0, 255));
          by = 8'($urandom_range(0, 255));
          if (dir_x == 1) begin
            b0[X_SIGN_BIT] = 1'b0;
            bx[7]          = 1'b1;
          end else if (dir_x == 0) begin
            b0[X_SIGN_BIT] = 1'b1;
            bx[7]          = 1'b0;
          end
          if (dir_y != 2) begin
            b0[Y_SIGN_BIT] = (dir_y == 0) ^ !y_up;
            by[7]          = !b0[Y_SIGN_BIT];
          end
          if ($urandom_range(0, 9) == 0) begin
            bx = 8'($urandom_range(0, 3));
            by = 8'($urandom_range(0, 3));
          end
          if ($urandom_range(0, 11) == 0) begin
            bx                 = 8'h00;
            by                 = 8'h00;
            b0[Y_SIGN_BIT:X_SIGN_BIT] = 2'b00;
          end
          send_byte(b0, CHK_PRED);
          send_byte(bx, CHK_PRED);
          send_byte(by, CHK_PRED);
        end
      end
    end

    // Drain and look for stray beats
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (pending_events.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, pending_events.size());
    end

    $display("tb: %0d bytes in, %0d result beats, %0d cycles with input held back",
             n_bytes, n_beats, n_in_held);
    $display("tb: both y directions, %0d clamps at zero, %0d at the far edge",
             n_clamp_lo, n_clamp_hi);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/pmt_pkg.sv
rtl/core/pmt_front.sv
rtl/core/pmt_queue.sv
rtl/core/pmt_back.sv
rtl/core/ps2_mouse_tracker_unit.sv
tb/tb.sv
